>>> rtl/bra_pkg.sv
// Shared types and constants for the bitmap run allocator.
`default_nettype none

package bra_pkg;

    localparam int CMD_W     = 3;
    localparam int IDX_W     = 10;
    localparam int LEN_W     = 11;
    localparam int ST_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int BIT_SEL_W = 3;
    localparam int CFG_W     = 8;
    localparam int PTR_W     = 8;    // byte pointer, holds 0..SPAN_BYTES
    localparam int SPAN_BYTES = 128; // bytes reachable by a 10-bit index

    localparam logic [CFG_W-1:0]  CFG_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] LSB_MASK  = 8'h01;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST    = 3'd0,
        CMD_SET     = 3'd1,
        CMD_CLR     = 3'd2,
        CMD_SEARCH  = 3'd3,
        CMD_CLR_ALL = 3'd4
    } cmd_t;

    localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
    localparam logic [ST_W-1:0] STAT_RANGE    = 2'd1;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic             item_load;
        logic             rd_byte;
        logic             bit_we;
        logic             search_init;
        logic             search_en;
        logic             sweep_we;
        logic             res_load;
        logic [ST_W-1:0]  res_status;
        logic             res_take_bit;
        logic             res_take_start;
        logic             out_load;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             oor;
        logic             area_empty;
        logic             hit;
        logic             search_end;
        logic             sweep_last;
        logic             out_free;
    } ctl_stat_t;

endpackage

`default_nettype wire

>>> rtl/bra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bra_ctrl.sv
// Command sequencer for the bitmap run allocator.
`default_nettype none

module bra_ctrl
    import bra_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ctl_stat_t st,
    output ctl_cmd_t       ctl
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_RMW,
        S_SEARCH,
        S_WIPE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.res_status = STAT_OK;
        case (state_reg)
            S_INIT: begin
                ctl.sweep_we = 1'b1;
                if (st.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    ctl.item_load = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (st.cmd)
                    CMD_TEST, CMD_SET, CMD_CLR: begin
                        if (st.oor) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = STAT_RANGE;
                            state_next     = S_DONE;
                        end else begin
                            ctl.rd_byte = 1'b1;
                            state_next  = S_RMW;
                        end
                    end
                    CMD_SEARCH: begin
                        if (st.area_empty) begin
                            ctl.res_load   = 1'b1;
                            ctl.res_status = STAT_NOT_FOUND;
                            state_next     = S_DONE;
                        end else begin
                            ctl.search_init = 1'b1;
                            state_next      = S_SEARCH;
                        end
                    end
                    CMD_CLR_ALL: begin
                        state_next = S_WIPE;
                    end
                    default: begin
                        // unused codes: no operation
                        ctl.res_load = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_RMW: begin
                ctl.bit_we       = (st.cmd inside {CMD_SET, CMD_CLR});
                ctl.res_load     = 1'b1;
                ctl.res_take_bit = (st.cmd == CMD_TEST);
                state_next       = S_DONE;
            end
            S_SEARCH: begin
                ctl.search_en = 1'b1;
                if (st.hit) begin
                    ctl.res_load       = 1'b1;
                    ctl.res_take_start = 1'b1;
                    state_next         = S_DONE;
                end else if (st.search_end) begin
                    ctl.res_load   = 1'b1;
                    ctl.res_status = STAT_NOT_FOUND;
                    state_next     = S_DONE;
                end
            end
            S_WIPE: begin
                ctl.sweep_we = 1'b1;
                if (st.sweep_last) begin
                    ctl.res_load = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (st.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bra_dpath.sv
// Datapath: bitmap memory, command registers, run scanner and result registers.
`default_nettype none

module bra_dpath
    import bra_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic [CMD_W-1:0] s_cmd,
    input  wire logic [IDX_W-1:0] s_bit_index,
    input  wire logic [LEN_W-1:0] s_run_length,
    input  wire ctl_cmd_t         ctl,
    output ctl_stat_t             st,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [ST_W-1:0]       m_status,
    output logic [IDX_W-1:0]      m_start_index,
    output logic                  m_bit_value
);

    localparam int AW       = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int AREA_MAX = (MAX_BYTES < SPAN_BYTES) ? MAX_BYTES : SPAN_BYTES;

    logic [CFG_W-1:0]  cfg_bytes_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [AW-1:0]     sweep_cnt_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  data_ptr_reg;
    logic              data_valid_reg;
    logic [LEN_W-1:0]  run_reg;
    logic [ST_W-1:0]   res_status_reg;
    logic [IDX_W-1:0]  res_start_reg;
    logic              res_bit_reg;
    logic              m_valid_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic [IDX_W-1:0]  m_start_reg;
    logic              m_bit_reg;

    logic [PTR_W-1:0]  area_bytes;
    logic [PTR_W-1:0]  idx_byte;
    logic              sweep_last;
    logic              search_issue;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] bit_mask;
    logic [BYTE_W-1:0] rmw_byte;
    logic [LEN_W-1:0]  scan_run;
    logic              scan_hit;
    logic [BIT_SEL_W-1:0] scan_bit;
    logic [IDX_W-1:0]  hit_pos;
    logic [LEN_W-1:0]  start_calc;

    // area in use, saturated to the storage and to the index span
    always_comb begin
        if (cfg_bytes_reg > CFG_W'(AREA_MAX)) begin
            area_bytes = PTR_W'(AREA_MAX);
        end else begin
            area_bytes = PTR_W'(cfg_bytes_reg);
        end
    end

    assign idx_byte   = PTR_W'(idx_reg[IDX_W-1:BIT_SEL_W]);
    assign sweep_last = (sweep_cnt_reg == AW'(MAX_BYTES - 1));
    assign search_issue = ctl.search_en && (rd_ptr_reg < area_bytes);

    assign bit_mask = LSB_MASK << idx_reg[BIT_SEL_W-1:0];
    assign rmw_byte = (cmd_reg == CMD_SET) ? (ram_rdata | bit_mask)
                                           : (ram_rdata & ~bit_mask);

    assign ram_we    = ctl.sweep_we || ctl.bit_we;
    assign ram_waddr = ctl.sweep_we ? sweep_cnt_reg : AW'(idx_byte);
    assign ram_wdata = ctl.sweep_we ? '0 : rmw_byte;
    assign ram_re    = ctl.rd_byte || search_issue;
    assign ram_raddr = ctl.search_en ? AW'(rd_ptr_reg) : AW'(idx_byte);

    bra_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // run scan across one byte, lowest bit first
    always_comb begin
        scan_run = run_reg;
        scan_hit = 1'b0;
        scan_bit = '0;
        for (int j = 0; j < BYTE_W; j++) begin
            if (ram_rdata[j]) begin
                scan_run = '0;
            end else begin
                scan_run = scan_run + LEN_W'(1);
            end
            if (!scan_hit && !ram_rdata[j] && (scan_run >= len_reg)) begin
                scan_hit = 1'b1;
                scan_bit = BIT_SEL_W'(j);
            end
        end
    end

    assign hit_pos    = {data_ptr_reg[PTR_W-2:0], scan_bit};
    assign start_calc = LEN_W'(hit_pos) + LEN_W'(1) - len_reg;

    always_comb begin
        st            = '0;
        st.cmd        = cmd_reg;
        st.oor        = (idx_byte >= area_bytes);
        st.area_empty = (area_bytes == '0);
        st.hit        = data_valid_reg && scan_hit;
        st.search_end = data_valid_reg && (data_ptr_reg == area_bytes - PTR_W'(1));
        st.sweep_last = sweep_last;
        st.out_free   = !m_valid_reg || m_ready;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_bytes_reg  <= CFG_RESET;
            sweep_cnt_reg  <= '0;
            rd_ptr_reg     <= '0;
            data_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_bytes_reg <= cfg_data;
            end
            if (ctl.sweep_we) begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + AW'(1);
            end
            if (ctl.search_init) begin
                rd_ptr_reg <= '0;
            end else if (search_issue) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            data_valid_reg <= search_issue;
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ctl.item_load) begin
            cmd_reg <= s_cmd;
            idx_reg <= s_bit_index;
            len_reg <= (s_run_length == '0) ? LEN_W'(1) : s_run_length;
        end
        data_ptr_reg <= rd_ptr_reg;
        if (ctl.search_init) begin
            run_reg <= '0;
        end else if (ctl.search_en && data_valid_reg) begin
            run_reg <= scan_run;
        end
        if (ctl.res_load) begin
            res_status_reg <= ctl.res_status;
            res_start_reg  <= ctl.res_take_start ? start_calc[IDX_W-1:0] : '0;
            res_bit_reg    <= ctl.res_take_bit ? ram_rdata[idx_reg[BIT_SEL_W-1:0]] : 1'b0;
        end
        if (ctl.out_load) begin
            m_status_reg <= res_status_reg;
            m_start_reg  <= res_start_reg;
            m_bit_reg    <= res_bit_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_start_index = m_start_reg;
    assign m_bit_value   = m_bit_reg;

endmodule

`default_nettype wire

>>> rtl/bitmap_run_allocator.sv
// Top level of the first-fit bitmap run allocator.
`default_nettype none

// Keeps one allocation bit per block (set = taken) in a byte-wide RAM of
// MAX_BYTES entries and runs one command item at a time: test, set or clear
// a bit, clear the whole bitmap, or find the lowest start of a free run of
// run_length bits (first fit, nothing is marked). Only the first
// bytes_in_use bytes (saturated to MAX_BYTES and to 128) are in use; a run
// must end inside that area. Steps, from the accept to the result being
// loaded into the output register: test/set/clear go through dispatch,
// byte read and read-modify-write; an out-of-range index or an unused
// command code ends at dispatch; a search goes through dispatch and then
// scans the bytes, one byte per cycle through the single RAM read port,
// ending at a hit or at the last byte of the saturated area (at dispatch
// when the area is empty), and clear all makes one RAM write per entry.
// After reset the block clears every RAM entry with s_ready low. The
// result sits in an output register, so a new item is taken while the
// previous result still waits for m_ready.
// bytes_in_use is written through the cfg channel, which is always ready;
// write it only while the block is idle.

module bitmap_run_allocator
    import bra_pkg::*;
#(
    parameter int MAX_BYTES = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // configuration: bytes_in_use
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    // command items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [CMD_W-1:0] s_cmd,
    input  wire logic [IDX_W-1:0] s_bit_index,
    input  wire logic [LEN_W-1:0] s_run_length,
    // result items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [ST_W-1:0]       m_status,
    output logic [IDX_W-1:0]      m_start_index,
    output logic                  m_bit_value
);

    ctl_cmd_t  ctl;
    ctl_stat_t st;

    assign cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    bra_dpath #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_cmd         (s_cmd),
        .s_bit_index   (s_bit_index),
        .s_run_length  (s_run_length),
        .ctl           (ctl),
        .st            (st),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_start_index (m_start_index),
        .m_bit_value   (m_bit_value)
    );

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in progress");

    // a start index is only reported with an ok status
    a_start_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |-> (m_start_index == '0))
        else $error("start index set on a failing result");

    // a set bit value only comes from a successful test
    a_bit_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bit_value |-> (m_status == STAT_OK))
        else $error("bit value set on a failing result");

    // a write-back never coincides with the clearing sweep
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.bit_we && ctl.sweep_we))
        else $error("bit write during clear sweep");

endmodule

`default_nettype wire
